>>> design/dmcf_pkg.sv
// dmcf_pkg: types and constants shared by the dual motor command framer
// no dependencies; imported by every module of the framer
package dmcf_pkg;

	localparam int unsigned AddrW       = 7;
	localparam int unsigned ByteW       = 8;
	localparam int unsigned SpeedW      = 16;
	localparam int unsigned SelW        = 2;
	localparam int unsigned MaxBytes    = 8;
	localparam int unsigned IdxW        = $clog2(MaxBytes);
	localparam int unsigned InDataW     = 32;
	localparam int unsigned OutUserW    = 2;

	localparam logic [AddrW-1:0] AddrReset = 7'd12;

	// command codes
	localparam logic CmdSpeed = 1'b0;
	localparam logic CmdFreq  = 1'b1;

	// motor numbers
	localparam logic [SelW-1:0] MotorOne = 2'd1;
	localparam logic [SelW-1:0] MotorTwo = 2'd2;

	// frame opcodes and fill byte
	localparam logic [ByteW-1:0] OpDirSet   = 8'hAA;
	localparam logic [ByteW-1:0] OpSpeedSet = 8'h82;
	localparam logic [ByteW-1:0] OpFreqSet  = 8'h84;
	localparam logic [ByteW-1:0] ByteFill   = 8'h01;

	// direction codes, motor one / motor two
	localparam logic [ByteW-1:0] DirFwdFwd = 8'h0A;
	localparam logic [ByteW-1:0] DirFwdRev = 8'h06;
	localparam logic [ByteW-1:0] DirRevFwd = 8'h09;
	localparam logic [ByteW-1:0] DirRevRev = 8'h05;

	localparam logic [ByteW-1:0] SpeedMax = 8'd255;
	localparam logic [ByteW-1:0] FreqMin  = 8'd1;
	localparam logic [ByteW-1:0] FreqMax  = 8'd5;

	// byte counts less one for each kind of request
	localparam logic [IdxW-1:0] LastIdxErr   = 3'd0;
	localparam logic [IdxW-1:0] LastIdxFreq  = 3'd3;
	localparam logic [IdxW-1:0] LastIdxSpeed = 3'd7;

	typedef struct packed {
		logic [ByteW-1:0]  frequency_code;
		logic signed [SpeedW-1:0] signed_speed;
		logic [SelW-1:0]   motor_select;
		logic              command;
	} item_t;

	typedef struct packed {
		logic [MaxBytes-1:0][ByteW-1:0] bytes;
		logic [IdxW-1:0]                last_idx;
		logic                           error;
	} frame_t;

endpackage

>>> design/dmcf_frame_build.sv
// dmcf_frame_build: holds motor speed and direction, builds the byte frames of one request
// depends on dmcf_pkg
module dmcf_frame_build (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dmcf_pkg::item_t               item,
	input  logic                          commit,
	input  logic [dmcf_pkg::AddrW-1:0]    device_address,
	output dmcf_pkg::frame_t              frame
);
	import dmcf_pkg::*;

	logic [ByteW-1:0]  speed_one_q, speed_two_q;
	logic              reverse_one_q, reverse_two_q;
	logic [ByteW-1:0]  speed_one_d, speed_two_d, dir_code, addr_byte, mag_val;
	logic              reverse_one_d, reverse_two_d, rev, upd;
	logic [SpeedW-1:0] mag16;
	logic              sel_ok, freq_ok;

	always_comb begin
		// magnitude with saturation, -32768 lands in the saturated range
		rev     = item.signed_speed[SpeedW-1];
		mag16   = rev ? (~item.signed_speed + 16'd1) : item.signed_speed;
		mag_val = (|mag16[SpeedW-1:ByteW]) ? SpeedMax : mag16[ByteW-1:0];

		sel_ok  = (item.motor_select == MotorOne) || (item.motor_select == MotorTwo);
		freq_ok = (item.frequency_code >= FreqMin) && (item.frequency_code <= FreqMax);
		upd     = (item.command == CmdSpeed) && sel_ok;

		speed_one_d   = speed_one_q;
		speed_two_d   = speed_two_q;
		reverse_one_d = reverse_one_q;
		reverse_two_d = reverse_two_q;
		if (upd && item.motor_select == MotorOne) begin
			speed_one_d   = mag_val;
			reverse_one_d = rev;
		end
		if (upd && item.motor_select == MotorTwo) begin
			speed_two_d   = mag_val;
			reverse_two_d = rev;
		end

		unique case ({reverse_one_d, reverse_two_d})
			2'b00:   dir_code = DirFwdFwd;
			2'b01:   dir_code = DirFwdRev;
			2'b10:   dir_code = DirRevFwd;
			default: dir_code = DirRevRev;
		endcase

		addr_byte = {device_address, 1'b0};

		frame.bytes    = '0;
		frame.last_idx = LastIdxErr;
		frame.error    = 1'b1;
		if (item.command == CmdFreq) begin
			if (freq_ok) begin
				frame.bytes[0] = addr_byte;
				frame.bytes[1] = OpFreqSet;
				frame.bytes[2] = item.frequency_code;
				frame.bytes[3] = ByteFill;
				frame.last_idx = LastIdxFreq;
				frame.error    = 1'b0;
			end
		end else if (sel_ok) begin
			frame.bytes[0] = addr_byte;
			frame.bytes[1] = OpDirSet;
			frame.bytes[2] = dir_code;
			frame.bytes[3] = ByteFill;
			frame.bytes[4] = addr_byte;
			frame.bytes[5] = OpSpeedSet;
			frame.bytes[6] = speed_one_d;
			frame.bytes[7] = speed_two_d;
			frame.last_idx = LastIdxSpeed;
			frame.error    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_one_q   <= '0;
			speed_two_q   <= '0;
			reverse_one_q <= 1'b0;
			reverse_two_q <= 1'b0;
		end else if (commit) begin
			speed_one_q   <= speed_one_d;
			speed_two_q   <= speed_two_d;
			reverse_one_q <= reverse_one_d;
			reverse_two_q <= reverse_two_d;
		end
	end

endmodule

>>> design/dmcf_byte_emit.sv
// dmcf_byte_emit: result register holding one built frame, sent a byte per cycle while m_tready is high
// depends on dmcf_pkg
module dmcf_byte_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load_valid,
	input  dmcf_pkg::frame_t              frame,
	output logic                          load_ready,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dmcf_pkg::ByteW-1:0]    m_tdata,
	output logic [dmcf_pkg::OutUserW-1:0] m_tuser,
	output logic                          m_tlast
);
	import dmcf_pkg::*;

	frame_t          frame_s2;
	logic            valid_s2;
	logic [IdxW-1:0] idx_q;
	logic            take, at_end, done;

	assign take       = valid_s2 && m_tready;
	assign at_end     = (idx_q == frame_s2.last_idx);
	assign done       = take && at_end;
	assign load_ready = !valid_s2 || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (load_ready) begin
			valid_s2 <= load_valid;
			idx_q    <= '0;
		end else if (take) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ready && load_valid) begin
			frame_s2 <= frame;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = frame_s2.bytes[idx_q];
	assign m_tlast  = at_end;
	// frame end on every fourth byte (index 3 and 7), never on an error result
	assign m_tuser  = {frame_s2.error, (idx_q[1:0] == 2'd3) && !frame_s2.error};

endmodule

>>> design/dual_motor_command_framer_unit.sv
// dual_motor_command_framer_unit: top level of the dual motor command framer
// depends on dmcf_pkg, dmcf_frame_build, dmcf_byte_emit
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+-------------------------------------------
//  s_*      | in  | s_tvalid / s_tready   | tdata: motor_select, signed_speed,
//           |     |                       |        frequency_code; tuser: command
//  m_*      | out | m_tvalid / m_tready   | tdata: out_byte; tuser: frame_end, error;
//           |     |                       | tlast: last
//  cfg_*    | in  | cfg_valid / cfg_ready | cfg_data: device_address
//
// a speed request yields 8 output bytes, a frequency request 4, an invalid one 1;
// the output port, one byte per cycle while m_tready is high, sets the sustained rate
// a request waits in the input register while the previous frame drains, so the
// next request is taken with no gap between frames
// reset clears valid flags, stored speeds and directions, address back to 12
// a stall on m_tready holds the current byte and backs up into s_tready
module dual_motor_command_framer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [1:0] motor_select, [17:2] signed_speed, [25:18] frequency_code, [31:26] zero
	input  logic [dmcf_pkg::InDataW-1:0]  s_tdata,
	// [0] command
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [7:0] out_byte
	output logic [dmcf_pkg::ByteW-1:0]    m_tdata,
	// [0] frame_end, [1] error
	output logic [dmcf_pkg::OutUserW-1:0] m_tuser,
	output logic                          m_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dmcf_pkg::AddrW-1:0]    cfg_data
);
	import dmcf_pkg::*;

	logic [AddrW-1:0] device_address_q;
	item_t            item_s1;
	logic             valid_s1;
	logic             load_ready;
	logic             commit;
	frame_t           frame;

	// config register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= AddrReset;
		end else if (cfg_valid) begin
			device_address_q <= cfg_data;
		end
	end

	// input register: free, or emptied this cycle into the result register
	assign commit   = valid_s1 && load_ready;
	assign s_tready = !valid_s1 || load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.command        <= s_tuser;
			item_s1.motor_select   <= s_tdata[1:0];
			item_s1.signed_speed   <= s_tdata[17:2];
			item_s1.frequency_code <= s_tdata[25:18];
		end
	end

	// motor state updates on the same edge the frame moves to the result register
	dmcf_frame_build u_build (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item_s1),
		.commit         (commit),
		.device_address (device_address_q),
		.frame          (frame)
	);

	dmcf_byte_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.frame      (frame),
		.load_ready (load_ready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

>>> design/dmcf_checker.sv
// dmcf_checker: port-level checks for the dual motor command framer
// depends on dmcf_pkg; bound to dual_motor_command_framer_unit
module dmcf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [dmcf_pkg::ByteW-1:0]    m_tdata,
	input logic [dmcf_pkg::OutUserW-1:0] m_tuser,
	input logic                          m_tlast
);
	import dmcf_pkg::*;

	// an error result stands alone
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
		else $error("error result not single");

	// an error result carries a zero byte
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == '0)
		else $error("error result with nonzero byte");

	// a good request always ends on a stop
	a_last_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && !m_tuser[1] |-> m_tuser[0])
		else $error("request ends without frame end");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind dual_motor_command_framer_unit dmcf_checker u_dmcf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

>>> tb/sv/dual_motor_command_framer_unit_tb.sv
`timescale 1ns / 100ps
// dual_motor_command_framer_unit_tb: self-checking bench for the motor command framer
// depends on dmcf_pkg and dual_motor_command_framer_unit; needs no files or arguments
module dual_motor_command_framer_unit_tb;
	import dmcf_pkg::*;

	// motor numbers that the framer must refuse
	localparam logic [SelW-1:0] MotorNone = 2'd0;
	localparam logic [SelW-1:0] MotorBad  = 2'd3;

	// generous ceiling: worst case is 8 bytes per request, each behind a long stall
	localparam int CycleLimit = 600000;
	// quiet cycles after the last byte, to catch anything extra
	localparam int TailCycles = 16;
	localparam int PrintCap   = 40;

	typedef struct {
		logic [ByteW-1:0] bus_byte;
		logic             frame_end;
		logic             last;
		logic             error;
	} bus_byte_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [ByteW-1:0]    m_tdata;
	logic [OutUserW-1:0] m_tuser;
	logic                m_tlast;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [AddrW-1:0]    cfg_data;

	// bytes the framer still owes, oldest first
	bus_byte_t bus_byte_q[$];

	// shadow of the framer state
	logic [AddrW-1:0] dev_addr;
	logic [ByteW-1:0] speed_m1;
	logic [ByteW-1:0] speed_m2;
	logic             rev_m1;
	logic             rev_m2;

	int  err_count     = 0;
	int  result_count  = 0;
	int  cycle_count   = 0;
	int  rx_hold_left  = 0;
	bit  tx_gaps_on    = 1'b0;
	bit  rx_stalls_on  = 1'b0;

	dual_motor_command_framer_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop if the bench hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// idle lengths: mostly short, now and then a long one
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 8);
		return $urandom_range(20, 40);
	endfunction

	function automatic void push_byte(logic [ByteW-1:0] b, logic fe, logic lst, logic er);
		bus_byte_t e;
		e.bus_byte  = b;
		e.frame_end = fe;
		e.last      = lst;
		e.error     = er;
		bus_byte_q.push_back(e);
	endfunction

	// one bus frame: address with write bit clear, three payload bytes, stop after the last
	function automatic void push_frame(logic [ByteW-1:0] b1, logic [ByteW-1:0] b2,
			logic [ByteW-1:0] b3, logic is_last);
		push_byte({dev_addr, 1'b0}, 1'b0, 1'b0, 1'b0);
		push_byte(b1, 1'b0, 1'b0, 1'b0);
		push_byte(b2, 1'b0, 1'b0, 1'b0);
		push_byte(b3, 1'b1, is_last, 1'b0);
	endfunction

	function automatic logic [ByteW-1:0] direction_byte();
		case ({rev_m1, rev_m2})
			2'b00: return DirFwdFwd;
			2'b01: return DirFwdRev;
			2'b10: return DirRevFwd;
			default: return DirRevRev;
		endcase
	endfunction

	// bus bytes caused by one accepted request, with the shadow state updated on the way
	function automatic void encode_request(item_t req);
		int               spd;
		logic             rev;
		logic [ByteW-1:0] mag;
		if (req.command == CmdFreq) begin
			if (req.frequency_code < FreqMin || req.frequency_code > FreqMax)
				push_byte('0, 1'b0, 1'b1, 1'b1);
			else
				push_frame(OpFreqSet, req.frequency_code, ByteFill, 1'b1);
			return;
		end
		if (req.motor_select != MotorOne && req.motor_select != MotorTwo) begin
			push_byte('0, 1'b0, 1'b1, 1'b1);
			return;
		end
		spd = req.signed_speed;
		rev = (spd < 0);
		if (spd < 0)
			spd = -spd;
		mag = (spd > 255) ? SpeedMax : spd[ByteW-1:0];
		if (req.motor_select == MotorOne) begin
			rev_m1   = rev;
			speed_m1 = mag;
		end else begin
			rev_m2   = rev;
			speed_m2 = mag;
		end
		push_frame(OpDirSet, direction_byte(), ByteFill, 1'b0);
		push_frame(OpSpeedSet, speed_m1, speed_m2, 1'b1);
	endfunction

	task automatic note_mismatch(input string what, input int got, input int want);
		err_count++;
		if (err_count <= PrintCap)
			$display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
				result_count, what, got, want);
	endtask

	// offer one request, hold it until taken, then maybe idle the input
	task automatic send_request(input item_t req);
		int gap;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata  = {{(InDataW-26){1'b0}}, req.frequency_code, req.signed_speed,
			req.motor_select};
		s_tuser  = req.command;
		do @(posedge clk); while (!s_tready);
		encode_request(req);
		gap = (tx_gaps_on && $urandom_range(0, 2) == 0) ? gap_length() : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_fields(input logic cmd, input logic [SelW-1:0] sel,
			input int spd, input int code);
		item_t req;
		req.command        = cmd;
		req.motor_select   = sel;
		req.signed_speed   = SpeedW'(spd);
		req.frequency_code = ByteW'(code);
		send_request(req);
	endtask

	// drop the request line and wait until every owed byte has come out
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (bus_byte_q.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_device_address(input logic [AddrW-1:0] addr);
		wait_drained();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = addr;
		do @(posedge clk); while (!cfg_ready);
		dev_addr = addr;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic item_t random_request();
		item_t req;
		int    kind;
		int    r;
		// fields the request does not use still get random values
		req.command        = CmdSpeed;
		req.motor_select   = SelW'($urandom_range(0, 3));
		req.signed_speed   = SpeedW'($urandom);
		req.frequency_code = ByteW'($urandom);
		kind = $urandom_range(0, 99);
		if (kind < 55) begin
			req.motor_select = $urandom_range(0, 1) ? MotorOne : MotorTwo;
			r = $urandom_range(0, 9);
			if (r < 4)
				req.signed_speed = SpeedW'($urandom_range(0, 600) - 300);
			else if (r < 6)
				req.signed_speed = SpeedW'(($urandom_range(0, 1) ? 1 : -1) *
					$urandom_range(250, 260));
		end else if (kind < 80) begin
			req.command        = CmdFreq;
			req.frequency_code = ByteW'($urandom_range(FreqMin, FreqMax));
		end else if (kind < 88) begin
			req.motor_select = $urandom_range(0, 1) ? MotorNone : MotorBad;
		end else begin
			req.command = CmdFreq;
			if ($urandom_range(0, 1))
				req.frequency_code = '0;
			else
				req.frequency_code = ByteW'($urandom_range(FreqMax + 1, 255));
		end
		return req;
	endfunction

	// receiver side: random stalls plus a long hold-off counted down here
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				m_tready = 1'b0;
				rx_hold_left--;
			end else if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else if (rx_stalls_on && $urandom_range(0, 7) == 0) begin
				m_tready   = 1'b0;
				stall_left = gap_length() - 1;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// every byte taken off the output is matched against the oldest owed byte
	always @(posedge clk) begin
		bus_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			result_count++;
			if (bus_byte_q.size() == 0) begin
				note_mismatch("unexpected byte", m_tdata, 0);
			end else begin
				want = bus_byte_q.pop_front();
				if (m_tdata !== want.bus_byte)
					note_mismatch("out_byte", m_tdata, want.bus_byte);
				if (m_tuser[0] !== want.frame_end)
					note_mismatch("frame_end", m_tuser[0], want.frame_end);
				if (m_tlast !== want.last)
					note_mismatch("last", m_tlast, want.last);
				if (m_tuser[1] !== want.error)
					note_mismatch("error", m_tuser[1], want.error);
			end
		end
	end

	// edges of every field, both motors, all direction codes, both kinds of refusal
	task automatic test_directed();
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		// reset state: address 12, both forward, both speeds zero
		send_fields(CmdSpeed, MotorOne, 0, 0);
		send_fields(CmdSpeed, MotorOne, 1, 0);
		send_fields(CmdSpeed, MotorTwo, -1, 0);
		send_fields(CmdSpeed, MotorOne, -255, 0);
		send_fields(CmdSpeed, MotorTwo, 255, 0);
		// magnitudes past 255 saturate, most negative value included
		send_fields(CmdSpeed, MotorOne, 256, 0);
		send_fields(CmdSpeed, MotorTwo, 32767, 0);
		send_fields(CmdSpeed, MotorOne, -32768, 0);
		send_fields(CmdSpeed, MotorTwo, -256, 0);
		// refused motors leave the stored speeds alone
		send_fields(CmdSpeed, MotorNone, 100, 3);
		send_fields(CmdSpeed, MotorBad, -5, 255);
		send_fields(CmdSpeed, MotorTwo, 0, 255);
		// frequency codes at and past both bounds
		send_fields(CmdFreq, MotorOne, 0, 0);
		send_fields(CmdFreq, MotorTwo, 77, 1);
		send_fields(CmdFreq, MotorNone, 0, 5);
		send_fields(CmdFreq, MotorOne, 0, 6);
		send_fields(CmdFreq, MotorBad, -1, 255);
		send_fields(CmdFreq, MotorBad, -32768, 3);
		send_fields(CmdSpeed, MotorOne, 0, 0);
		wait_drained();
	endtask

	// address extremes show up in every frame
	task automatic test_device_address();
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
		write_device_address('0);
		send_fields(CmdSpeed, MotorOne, 17, 0);
		send_fields(CmdFreq, MotorOne, 0, 2);
		send_fields(CmdFreq, MotorOne, 0, 9);
		write_device_address({AddrW{1'b1}});
		send_fields(CmdSpeed, MotorTwo, -200, 0);
		send_fields(CmdFreq, MotorOne, 0, 4);
		send_fields(CmdSpeed, MotorBad, 0, 0);
		write_device_address(AddrReset);
		send_fields(CmdFreq, MotorTwo, 0, 1);
		wait_drained();
	endtask

	// receiver holds off while requests keep coming, so the input side must stall
	task automatic test_backpressure();
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		rx_hold_left = 150;
		repeat (14)
			send_fields(CmdSpeed, $urandom_range(0, 1) ? MotorOne : MotorTwo,
				$urandom_range(0, 1000) - 500, $urandom);
		// sender waits for every owed byte before going on
		wait_drained();
		rx_stalls_on = 1'b1;
		repeat (4)
			send_request(random_request());
		wait_drained();
	endtask

	// random mix in phases, each with its own address and idling pattern
	task automatic test_random_mix();
		for (int phase = 0; phase < 4; phase++) begin
			write_device_address(AddrW'($urandom_range(0, 127)));
			tx_gaps_on   = (phase == 0 || phase == 2);
			rx_stalls_on = (phase == 0 || phase == 3);
			repeat (80)
				send_request(random_request());
		end
		wait_drained();
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		dev_addr  = AddrReset;
		speed_m1  = '0;
		speed_m2  = '0;
		rev_m1    = 1'b0;
		rev_m2    = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_device_address();
		test_backpressure();
		test_random_mix();

		wait_drained();
		repeat (TailCycles) @(posedge clk);
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
